// ===== rtl/core/i2c_master_bit_engine_top_defines.svh =====
// Assertion macros for the I2C master bit engine checker.
// Depends on nothing; included by the checker file.
`ifndef I2C_MASTER_BIT_ENGINE_TOP_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_TOP_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define I2CMB_ASSERT_IMP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Property checked on every clock edge, reset included.
`define I2CMB_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== rtl/core/i2cmb_pkg.sv =====
// Shared types and constants for the I2C master bit engine.
// No dependencies; imported by every module of the block.
package i2cmb_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } t_cmd;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'd0,
        PH_ST_A   = 5'd1,
        PH_ST_B   = 5'd2,
        PH_ST_C   = 5'd3,
        PH_SP_A   = 5'd4,
        PH_SP_B   = 5'd5,
        PH_SP_C   = 5'd6,
        PH_WR_LO  = 5'd7,
        PH_WR_HI  = 5'd8,
        PH_WA_LO  = 5'd9,
        PH_WA_HI  = 5'd10,
        PH_WA_END = 5'd11,
        PH_RD_LO  = 5'd12,
        PH_RD_HI  = 5'd13,
        PH_RN_LO  = 5'd14,
        PH_RN_HI  = 5'd15,
        PH_RN_END = 5'd16
    } t_phase;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [BYTE_W-1:0] write_byte;
        logic              sda_in;
    } t_in_item;

    typedef struct packed {
        logic              scl_out;
        logic              sda_out;
        logic              busy_res;
        logic              done_res;
        logic              ack_bit;
        logic [BYTE_W-1:0] read_byte;
        logic              rejected;
    } t_out_item;

endpackage

// ===== rtl/core/i2cmb_seq.sv =====
// Phase sequencer of the I2C master bit engine: line state and its update.
// Depends on i2cmb_pkg; instantiated by i2c_master_bit_engine_top.
module i2cmb_seq
    import i2cmb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [BYTE_W-1:0] i_phase_ticks,
    input  t_in_item          i_item,
    output t_out_item         o_result
);

    t_phase            r_phase, n_phase;
    logic [3:0]        r_bit_count, n_bit_count;
    logic [BYTE_W-1:0] r_shift, n_shift;
    logic [BYTE_W-1:0] r_phase_count, n_phase_count;
    logic              r_scl, n_scl;
    logic              r_sda, n_sda;
    logic              r_ack, n_ack;
    logic [BYTE_W-1:0] r_last_read, n_last_read;

    t_phase            ph1;
    logic [BYTE_W-1:0] sh1;
    logic              rejected;
    logic              done;

    always_comb begin : next_state
        logic              is_cmd;
        logic [3:0]        bc1;
        logic [3:0]        bc_inc;
        logic [BYTE_W-1:0] pc1;
        logic              phase_end;
        is_cmd   = (i_item.cmd >= CMD_START) && (i_item.cmd <= CMD_READ);
        ph1      = r_phase;
        sh1      = r_shift;
        bc1      = r_bit_count;
        pc1      = r_phase_count;
        rejected = 1'b0;
        if (r_phase != PH_IDLE) begin
            rejected = is_cmd;
        end else if (is_cmd) begin
            pc1 = '0;
            bc1 = '0;
            unique case (i_item.cmd)
                CMD_START: ph1 = PH_ST_A;
                CMD_STOP:  ph1 = PH_SP_A;
                CMD_WRITE: begin
                    ph1 = PH_WR_LO;
                    sh1 = i_item.write_byte;
                end
                default: begin
                    ph1 = PH_RD_LO;
                    sh1 = '0;
                end
            endcase
        end

        bc_inc        = bc1 + 4'd1;
        phase_end     = ({1'b0, pc1} + 9'd1) >= {1'b0, i_phase_ticks};
        n_phase       = ph1;
        n_shift       = sh1;
        n_bit_count   = bc1;
        n_phase_count = pc1;
        n_ack         = r_ack;
        n_last_read   = r_last_read;
        done          = 1'b0;

        if (ph1 != PH_IDLE) begin
            if (phase_end) begin
                n_phase_count = '0;
                unique case (ph1)
                    PH_ST_A:  n_phase = PH_ST_B;
                    PH_ST_B:  n_phase = PH_ST_C;
                    PH_SP_A:  n_phase = PH_SP_B;
                    PH_SP_B:  n_phase = PH_SP_C;
                    PH_WR_LO: n_phase = PH_WR_HI;
                    PH_WR_HI: begin
                        n_shift     = {sh1[BYTE_W-2:0], 1'b0};
                        n_bit_count = bc_inc;
                        n_phase     = (bc_inc >= BITS_PER_BYTE) ? PH_WA_LO : PH_WR_LO;
                    end
                    PH_WA_LO: n_phase = PH_WA_HI;
                    PH_WA_HI: begin
                        n_ack   = i_item.sda_in;
                        n_phase = PH_WA_END;
                    end
                    PH_RD_LO: n_phase = PH_RD_HI;
                    PH_RD_HI: begin
                        n_shift     = {sh1[BYTE_W-2:0], i_item.sda_in};
                        n_bit_count = bc_inc;
                        n_phase     = (bc_inc >= BITS_PER_BYTE) ? PH_RN_LO : PH_RD_LO;
                    end
                    PH_RN_LO: n_phase = PH_RN_HI;
                    PH_RN_HI: n_phase = PH_RN_END;
                    PH_RN_END: begin
                        n_last_read = sh1;
                        n_phase     = PH_IDLE;
                    end
                    default: n_phase = PH_IDLE;
                endcase
                done = (n_phase == PH_IDLE);
            end else begin
                n_phase_count = pc1 + 8'd1;
            end
        end
    end

    always_comb begin : drive_lines
        n_scl = r_scl;
        n_sda = r_sda;
        unique case (ph1)
            PH_ST_A, PH_SP_C: begin
                n_scl = 1'b1;
                n_sda = 1'b1;
            end
            PH_ST_B, PH_SP_B: begin
                n_scl = 1'b1;
                n_sda = 1'b0;
            end
            PH_ST_C, PH_SP_A: begin
                n_scl = 1'b0;
                n_sda = 1'b0;
            end
            PH_WR_LO: begin
                n_scl = 1'b0;
                n_sda = sh1[BYTE_W-1];
            end
            PH_WR_HI: begin
                n_scl = 1'b1;
                n_sda = sh1[BYTE_W-1];
            end
            PH_WA_HI, PH_RD_HI, PH_RN_HI: begin
                n_scl = 1'b1;
                n_sda = 1'b1;
            end
            PH_WA_LO, PH_WA_END, PH_RD_LO, PH_RN_LO, PH_RN_END: begin
                n_scl = 1'b0;
                n_sda = 1'b1;
            end
            default: begin
                n_scl = r_scl;
                n_sda = r_sda;
            end
        endcase
    end

    always_comb begin
        o_result.scl_out   = n_scl;
        o_result.sda_out   = n_sda;
        o_result.busy_res  = (n_phase != PH_IDLE);
        o_result.done_res  = done;
        o_result.ack_bit   = n_ack;
        o_result.read_byte = n_last_read;
        o_result.rejected  = rejected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_bit_count   <= '0;
            r_shift       <= '0;
            r_phase_count <= '0;
            r_scl         <= 1'b1;
            r_sda         <= 1'b1;
            r_ack         <= 1'b0;
            r_last_read   <= '0;
        end else if (i_en) begin
            r_phase       <= n_phase;
            r_bit_count   <= n_bit_count;
            r_shift       <= n_shift;
            r_phase_count <= n_phase_count;
            r_scl         <= n_scl;
            r_sda         <= n_sda;
            r_ack         <= n_ack;
            r_last_read   <= n_last_read;
        end
    end

endmodule

// ===== rtl/core/i2c_master_bit_engine_top.sv =====
// Top level of the I2C master bit engine: handshake, input and result registers.
// Depends on i2cmb_pkg and i2cmb_seq.
// One item per clock while the result is not stalled: each item passes an input register,
// one pass of the phase sequencer and a result register, in that order; a stalled result
// holds both registers and raises o_in_stall only when both are full. phase_ticks sets
// how many items each half-bit phase lasts.
module i2c_master_bit_engine_top
    import i2cmb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [BYTE_W-1:0] i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_item
);

    logic [BYTE_W-1:0] r_phase_ticks;
    logic              r_in_valid;
    t_in_item          r_in_item;
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic              out_free;
    logic              advance;
    logic              in_take;
    t_out_item         result;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign in_take    = !r_in_valid || advance;
    assign o_in_stall = !in_take;

    i2cmb_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (advance),
        .i_phase_ticks (r_phase_ticks),
        .i_item        (r_in_item),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= 8'd1;
        end else if (i_cfg_we) begin
            r_phase_ticks <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== rtl/core/i2cmb_checker.sv =====
// Port-level checks for the I2C master bit engine, bound to its top level.
// Depends on i2cmb_pkg and i2c_master_bit_engine_top_defines.svh.
`include "i2c_master_bit_engine_top_defines.svh"

module i2cmb_checker
    import i2cmb_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input t_out_item         o_out_item
);

    `I2CMB_ASSERT_IMP(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
    `I2CMB_ASSERT_IMP(a_stall_only_full, i_clk, i_rst_n, o_in_stall |-> o_out_valid && i_out_stall)
    `I2CMB_ASSERT_IMP(a_done_not_busy, i_clk, i_rst_n, o_out_valid && o_out_item.done_res |-> !o_out_item.busy_res)
    `I2CMB_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall)

endmodule

bind i2c_master_bit_engine_top i2cmb_checker u_i2cmb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

// ===== tb/tb.sv =====
// Self-checking bench for the I2C master bit engine: directed and random tick/command items,
// random idling on both channels, and an item-level predictor of the SCL/SDA sequencer.
// Depends on i2cmb_pkg and i2c_master_bit_engine_top.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cmb_pkg::*;

    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
    localparam int SDA_LOW = 0;
    localparam int SDA_HIGH = 1;
    localparam int SDA_RAND = 2;
    localparam int MAX_WAIT = 14;
    localparam int LONG_HOLD = 80;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 240;
    localparam int PRINT_LIMIT = 30;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [BYTE_W-1:0] i_cfg_wdata;
    logic              i_in_valid;
    logic              o_in_stall;
    t_in_item          i_in_item;
    logic              o_out_valid;
    logic              i_out_stall;
    t_out_item         o_out_item;

    i2c_master_bit_engine_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    t_phase      bus_phase;
    logic [3:0]  bit_idx;
    logic [7:0]  shift_reg;
    logic [7:0]  tick_count;
    logic        scl_drv;
    logic        sda_drv;
    logic        ack_held;
    logic [7:0]  rx_held;
    logic [7:0]  ticks_per_phase;

    t_out_item   pending_results[$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          in_gap = 0;
    bit          in_held = 1'b0;
    bit          no_idle = 1'b0;
    bit          hold_request = 1'b0;
    int          idle_cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic bus_reset();
        bus_phase = PH_IDLE;
        bit_idx = '0;
        shift_reg = '0;
        tick_count = '0;
        scl_drv = 1'b1;
        sda_drv = 1'b1;
        ack_held = 1'b0;
        rx_held = '0;
        ticks_per_phase = 8'd1;
    endtask

    function automatic t_out_item bus_step(t_in_item it);
        t_out_item r;
        t_phase    nxt;
        logic      is_cmd;
        logic      rej;
        logic      fin;
        is_cmd = (it.cmd >= CMD_START) && (it.cmd <= CMD_READ);
        rej = 1'b0;
        fin = 1'b0;
        if (bus_phase != PH_IDLE) begin
            rej = is_cmd;
        end else if (is_cmd) begin
            tick_count = '0;
            bit_idx = '0;
            case (it.cmd)
                CMD_START: bus_phase = PH_ST_A;
                CMD_STOP:  bus_phase = PH_SP_A;
                CMD_WRITE: begin
                    bus_phase = PH_WR_LO;
                    shift_reg = it.write_byte;
                end
                default: begin
                    bus_phase = PH_RD_LO;
                    shift_reg = '0;
                end
            endcase
        end
        if (bus_phase != PH_IDLE) begin
            case (bus_phase)
                PH_ST_A, PH_SP_C:                 {scl_drv, sda_drv} = 2'b11;
                PH_ST_B, PH_SP_B:                 {scl_drv, sda_drv} = 2'b10;
                PH_ST_C, PH_SP_A:                 {scl_drv, sda_drv} = 2'b00;
                PH_WR_LO:                         {scl_drv, sda_drv} = {1'b0, shift_reg[7]};
                PH_WR_HI:                         {scl_drv, sda_drv} = {1'b1, shift_reg[7]};
                PH_WA_HI, PH_RD_HI, PH_RN_HI:     {scl_drv, sda_drv} = 2'b11;
                PH_WA_LO, PH_WA_END, PH_RD_LO,
                PH_RN_LO, PH_RN_END:              {scl_drv, sda_drv} = 2'b01;
                default: ;
            endcase
            if ({1'b0, tick_count} + 9'd1 >= {1'b0, ticks_per_phase}) begin
                nxt = PH_IDLE;
                case (bus_phase)
                    PH_ST_A:  nxt = PH_ST_B;
                    PH_ST_B:  nxt = PH_ST_C;
                    PH_SP_A:  nxt = PH_SP_B;
                    PH_SP_B:  nxt = PH_SP_C;
                    PH_WR_LO: nxt = PH_WR_HI;
                    PH_WR_HI: begin
                        shift_reg = {shift_reg[6:0], 1'b0};
                        bit_idx = bit_idx + 4'd1;
                        nxt = (bit_idx >= BITS_PER_BYTE) ? PH_WA_LO : PH_WR_LO;
                    end
                    PH_WA_LO: nxt = PH_WA_HI;
                    PH_WA_HI: begin
                        ack_held = it.sda_in;
                        nxt = PH_WA_END;
                    end
                    PH_RD_LO: nxt = PH_RD_HI;
                    PH_RD_HI: begin
                        shift_reg = {shift_reg[6:0], it.sda_in};
                        bit_idx = bit_idx + 4'd1;
                        nxt = (bit_idx >= BITS_PER_BYTE) ? PH_RN_LO : PH_RD_LO;
                    end
                    PH_RN_LO: nxt = PH_RN_HI;
                    PH_RN_HI: nxt = PH_RN_END;
                    PH_RN_END: rx_held = shift_reg;
                    default: nxt = PH_IDLE;
                endcase
                bus_phase = nxt;
                tick_count = '0;
                fin = (nxt == PH_IDLE);
            end else begin
                tick_count = tick_count + 8'd1;
            end
        end
        r.scl_out = scl_drv;
        r.sda_out = sda_drv;
        r.busy_res = (bus_phase != PH_IDLE);
        r.done_res = fin;
        r.ack_bit = ack_held;
        r.read_byte = rx_held;
        r.rejected = rej;
        return r;
    endfunction

    function automatic int draw_wait();
        return no_idle ? 0 : int'($urandom_range(0, MAX_WAIT));
    endfunction

    function automatic logic pick_sda(input int sel);
        case (sel)
            SDA_LOW:  return 1'b0;
            SDA_HIGH: return 1'b1;
            default:  return 1'($urandom_range(0, 1));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (pending_results.size() == 0) begin
            report_mismatch("item with nothing pending", {got.read_byte}, 8'h00);
        end else begin
            want = pending_results.pop_front();
            if (got.scl_out !== want.scl_out)
                report_mismatch("scl_out", 8'(got.scl_out), 8'(want.scl_out));
            if (got.sda_out !== want.sda_out)
                report_mismatch("sda_out", 8'(got.sda_out), 8'(want.sda_out));
            if (got.busy_res !== want.busy_res)
                report_mismatch("busy_res", 8'(got.busy_res), 8'(want.busy_res));
            if (got.done_res !== want.done_res)
                report_mismatch("done_res", 8'(got.done_res), 8'(want.done_res));
            if (got.ack_bit !== want.ack_bit)
                report_mismatch("ack_bit", 8'(got.ack_bit), 8'(want.ack_bit));
            if (got.read_byte !== want.read_byte)
                report_mismatch("read_byte", got.read_byte, want.read_byte);
            if (got.rejected !== want.rejected)
                report_mismatch("rejected", 8'(got.rejected), 8'(want.rejected));
        end
    endtask

    task automatic send_item(input logic [2:0] c, input logic [7:0] wb, input logic sda);
        t_in_item it;
        it.cmd = c;
        it.write_byte = wb;
        it.sda_in = sda;
        if (in_gap > 0)
            repeat (in_gap) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(bus_step(it));
        items_sent++;
        in_gap = draw_wait();
        if (in_gap > 0) begin
            i_in_valid <= 1'b0;
            in_held = 1'b0;
        end else begin
            in_held = 1'b1;
        end
    endtask

    task automatic hold_input();
        if (in_held) begin
            i_in_valid <= 1'b0;
            in_held = 1'b0;
            in_gap = 1;
        end
    endtask

    task automatic drain_results();
        hold_input();
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_phase_ticks(input logic [7:0] v);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        ticks_per_phase = v;
    endtask

    task automatic run_sequence(input logic [2:0] c, input logic [7:0] wb, input int sda_sel,
                                input int noise_pct);
        send_item(c, wb, pick_sda(sda_sel));
        while (bus_phase != PH_IDLE) begin
            if (int'($urandom_range(0, 99)) < noise_pct)
                send_item(3'($urandom_range(CMD_START, CMD_UNUSED_HI)),
                          8'($urandom_range(0, 255)), pick_sda(sda_sel));
            else
                send_item(CMD_TICK, 8'($urandom_range(0, 255)), pick_sda(sda_sel));
        end
    endtask

    task automatic test_idle_items();
        send_item(CMD_TICK, 8'hFF, 1'b1);
        send_item(CMD_TICK, 8'h00, 1'b0);
        for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++)
            send_item(3'(c), 8'h5A, 1'b1);
    endtask

    task automatic test_start_stop();
        run_sequence(CMD_START, 8'h00, SDA_RAND, 0);
        run_sequence(CMD_STOP, 8'hFF, SDA_RAND, 0);
    endtask

    task automatic test_write_read();
        run_sequence(CMD_WRITE, 8'hFF, SDA_HIGH, 0);
        run_sequence(CMD_READ, 8'h00, SDA_HIGH, 0);
    endtask

    task automatic test_busy_commands();
        send_item(CMD_READ, 8'h00, 1'b0);
        for (int c = CMD_START; c <= CMD_UNUSED_HI; c++)
            send_item(3'(c), 8'($urandom_range(0, 255)), 1'b0);
        while (bus_phase != PH_IDLE)
            send_item(CMD_TICK, 8'h00, 1'b0);
    endtask

    task automatic test_phase_ticks();
        set_phase_ticks(8'd2);
        run_sequence(CMD_READ, 8'h00, SDA_RAND, 5);
        set_phase_ticks(8'd0);
        run_sequence(CMD_START, 8'h00, SDA_RAND, 2);
        set_phase_ticks(8'd3);
        run_sequence(CMD_WRITE, 8'($urandom_range(0, 255)), SDA_LOW, 5);
        set_phase_ticks(8'd1);
    endtask

    task automatic test_backpressure();
        no_idle = 1'b1;
        hold_request = 1'b1;
        run_sequence(CMD_WRITE, 8'($urandom_range(0, 255)), SDA_RAND, 10);
        drain_results();
        run_sequence(CMD_READ, 8'h00, SDA_RAND, 0);
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic();
        int stop_at;
        int pick;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 5) == 0)
                no_idle = !no_idle;
            if ($urandom_range(0, 9) == 0)
                set_phase_ticks(($urandom_range(0, 7) == 0) ? 8'($urandom_range(4, 12))
                                                           : 8'($urandom_range(1, 3)));
            pick = $urandom_range(0, 99);
            if (pick < 80)
                run_sequence(3'($urandom_range(CMD_START, CMD_READ)),
                             8'($urandom_range(0, 255)), SDA_RAND, 5);
            else if (pick < 92)
                send_item(CMD_TICK, 8'($urandom_range(0, 255)), pick_sda(SDA_RAND));
            else
                send_item(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)),
                          8'($urandom_range(0, 255)), pick_sda(SDA_RAND));
        end
        no_idle = 1'b0;
    endtask

    initial begin : result_monitor
        int wait_cycles;
        i_out_stall <= 1'b1;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_request) begin
                wait_cycles = LONG_HOLD;
                hold_request = 1'b0;
            end else begin
                wait_cycles = draw_wait();
            end
            if (wait_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            check_result(o_out_item);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= '0;
        i_in_valid <= 1'b0;
        i_in_item <= '0;
        bus_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_items();
        test_start_stop();
        test_write_read();
        test_busy_commands();
        test_phase_ticks();
        test_backpressure();
        test_random_traffic();
        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/i2cmb_pkg.sv
rtl/core/i2cmb_seq.sv
rtl/core/i2c_master_bit_engine_top.sv
rtl/core/i2cmb_checker.sv
tb/tb.sv
